// ===== sv/bd2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bd2a_pkg;

   // Width of the binary number taken from each input beat.
   localparam int VALUE_BITS = 32;
   // Decimal digits needed for VALUE_BITS bits (1233 / 4096 is just below log10(2)).
   localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int REQ_W = ((VALUE_BITS + 7) / 8) * 8;
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int REM_W = $clog2(NUM_DIGITS + 1);
   localparam int DIGIT_W = 4;
   localparam int CHAR_W = 6;
   localparam int RSP_W = 8;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [REM_W-1:0] rem_type;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SKIP    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/bd2a_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bd2a_cell (
   input  wire                     clock,
   input  bd2a_pkg::cell_ctrl_type ctrl,
   input  wire                     lo_bit,
   input  bd2a_pkg::digit_type     lo_digit,
   output logic                    hi_bit,
   output bd2a_pkg::digit_type     digit
);

   bd2a_pkg::digit_type digit_ff;
   bd2a_pkg::digit_type digit_in;
   bd2a_pkg::digit_type corr;

   always_comb begin
      // Add 3 before the shift so that the doubled digit carries at ten.
      corr = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
      hi_bit = corr[3];
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = {corr[2:0], lo_bit};
      end else if (ctrl.shift) begin
         digit_in = lo_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

// ===== sv/bd2a_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bd2a_chain (
   input  wire                     clock,
   input  bd2a_pkg::cell_ctrl_type ctrl,
   input  wire                     lo_bit,
   output bd2a_pkg::digit_type     top_digit,
   output logic                    overflow
);

   logic                carry [bd2a_pkg::NUM_DIGITS+1];
   bd2a_pkg::digit_type digs  [bd2a_pkg::NUM_DIGITS+1];

   assign carry[0] = lo_bit;
   // Digits move toward the top cell when skipping or emitting; zeros enter at the bottom.
   assign digs[0] = '0;

   for (genvar i = 0; i < bd2a_pkg::NUM_DIGITS; i++) begin : g_cell
      bd2a_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .lo_bit   (carry[i]),
         .lo_digit (digs[i]),
         .hi_bit   (carry[i+1]),
         .digit    (digs[i+1])
      );
   end

   assign top_digit = digs[bd2a_pkg::NUM_DIGITS];
   assign overflow = carry[bd2a_pkg::NUM_DIGITS];

endmodule

`default_nettype wire

// ===== sv/binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary to decimal ASCII converter.
// The req channel takes one unsigned number per beat. The rsp channel returns its
// decimal digits as ASCII characters, most significant first, one per beat, with
// tlast on the final digit. Leading zeros are dropped; zero gives a single '0'.
// Conversion runs double dabble through a row of ten BCD digit cells, one input
// bit per cycle, so the bit-serial shift sets the pace: conversion shifts in all
// 32 bits, then the leading zero digits are skipped one per cycle, then the digits
// are emitted one per cycle while the receiver does not stall. req_tready returns
// only once the last digit is loaded into the output register, so a new number is
// not taken before the last one is through.
// The output register lets the last digit of one number wait while the next
// number is taken. A stalled receiver holds the current digit and pauses the
// digit emission; nothing is lost. Reset returns the controller to idle and
// drops any pending digit beat; no other state survives between items.
module binary_to_decimal_ascii (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [bd2a_pkg::REQ_W-1:0]   req_tdata,  // [31:0] value
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [bd2a_pkg::RSP_W-1:0]   rsp_tdata,  // [5:0] digit_char, [7:6] zero
   output logic                         rsp_tlast   // last
);

   bd2a_pkg::state_type     state_ff, state_in;
   logic [bd2a_pkg::VALUE_BITS-1:0] val_ff, val_in;
   bd2a_pkg::cnt_type       cnt_ff, cnt_in;
   bd2a_pkg::rem_type       rem_ff, rem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [bd2a_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   bd2a_pkg::cell_ctrl_type ctrl;
   bd2a_pkg::digit_type     top_digit;
   logic                    overflow;
   logic                    req_fire;
   logic                    out_free;
   logic                    skip_zero;

   assign req_tready = (state_ff == bd2a_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign skip_zero = (top_digit == '0) && (rem_ff > bd2a_pkg::rem_type'(1));

   always_comb begin
      ctrl.clear = req_fire;
      ctrl.convert = (state_ff == bd2a_pkg::ST_CONVERT);
      ctrl.shift = ((state_ff == bd2a_pkg::ST_SKIP) && skip_zero) ||
                   ((state_ff == bd2a_pkg::ST_EMIT) && out_free);
   end

   bd2a_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .lo_bit    (val_ff[bd2a_pkg::VALUE_BITS-1]),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         bd2a_pkg::ST_IDLE: begin
            if (req_fire) begin
               val_in = req_tdata[bd2a_pkg::VALUE_BITS-1:0];
               cnt_in = bd2a_pkg::cnt_type'(bd2a_pkg::VALUE_BITS - 1);
               state_in = bd2a_pkg::ST_CONVERT;
            end
         end
         bd2a_pkg::ST_CONVERT: begin
            val_in = {val_ff[bd2a_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - bd2a_pkg::cnt_type'(1);
            if (cnt_ff == '0) begin
               rem_in = bd2a_pkg::rem_type'(bd2a_pkg::NUM_DIGITS);
               state_in = bd2a_pkg::ST_SKIP;
            end
         end
         bd2a_pkg::ST_SKIP: begin
            if (skip_zero) begin
               rem_in = rem_ff - bd2a_pkg::rem_type'(1);
            end else begin
               state_in = bd2a_pkg::ST_EMIT;
            end
         end
         bd2a_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = bd2a_pkg::ASCII_ZERO + {2'b00, top_digit};
               rsp_last_in = (rem_ff == bd2a_pkg::rem_type'(1));
               rem_in = rem_ff - bd2a_pkg::rem_type'(1);
               if (rem_ff == bd2a_pkg::rem_type'(1)) begin
                  state_in = bd2a_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bd2a_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bd2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_char_ff};
   assign rsp_tlast = rsp_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == bd2a_pkg::ST_CONVERT))
      else $error("accepted number did not start conversion");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bd2a_pkg::ST_CONVERT) |-> !overflow)
      else $error("digit row overflowed during conversion");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] >= 6'd48 && rsp_tdata[5:0] <= 6'd57))
      else $error("emitted character is not a decimal digit");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bd2a_pkg::ST_EMIT) |-> (rem_ff != '0))
      else $error("emission ran past the digit count");

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state lost its one-hot code");

endmodule

`default_nettype wire
